// File: rtl/annexb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Annex B start-code delimiter.
// No dependencies; imported by every module of the block.
package annexb_pkg;

  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOne  = 8'h01;

  // Zeros held back while a start code may still be forming.
  localparam int MaxHeldZeros = 3;
  localparam int ZeroRunW     = $clog2(MaxHeldZeros + 1);
  // Beats per command: pending byte plus every held zero.
  localparam int BeatW        = $clog2(MaxHeldZeros + 2);
  localparam int UnitNumW     = 16;

  localparam int QueueDepthDefault = 4;

  // One command from the front: a burst of payload beats.
  // First beat carries head_byte, the rest are zeros.
  typedef struct packed {
    logic [7:0]          head_byte;
    logic                head_first;
    logic [BeatW-1:0]    beats;
    logic                close;
    logic [UnitNumW-1:0] unit_number;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/annexb_front.sv
`timescale 1ns / 1ps
// Front end: scans input bytes for start codes, tracks held zeros and the
// pending byte, issues at most one burst command per byte; uses annexb_pkg.
module annexb_front
  import annexb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic                in_unit_q, in_unit_d;
  logic                pend_valid_q, pend_valid_d;
  logic [7:0]          pend_byte_q, pend_byte_d;
  logic                pend_first_q, pend_first_d;
  logic [ZeroRunW-1:0] zero_run_q, zero_run_d;
  logic [UnitNumW-1:0] unit_cnt_q, unit_cnt_d;

  logic                accept;
  logic                do_push;
  logic                do_close;
  logic [7:0]          push_byte;
  logic [ZeroRunW-1:0] zeros_out;
  logic [BeatW-1:0]    beats;
  logic                is_start;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = (data_byte_i == ByteOne) && (zero_run_q >= ZeroRunW'(2));

  always_comb begin
    in_unit_d  = in_unit_q;
    zero_run_d = zero_run_q;
    do_push    = 1'b0;
    do_close   = 1'b0;
    push_byte  = data_byte_i;
    zeros_out  = '0;
    if (end_of_stream_i) begin
      if (in_unit_q) begin
        do_close  = 1'b1;
        zeros_out = zero_run_q;
      end
      in_unit_d  = 1'b0;
      zero_run_d = '0;
    end else if (!in_unit_q) begin
      if (data_byte_i == ByteZero) begin
        if (zero_run_q < ZeroRunW'(MaxHeldZeros)) zero_run_d = zero_run_q + 1'b1;
      end else begin
        if (is_start) in_unit_d = 1'b1;
        zero_run_d = '0;
      end
    end else if (data_byte_i == ByteZero) begin
      if (zero_run_q < ZeroRunW'(MaxHeldZeros)) begin
        zero_run_d = zero_run_q + 1'b1;
      end else begin
        // hold is full: oldest zero moves out as payload
        do_push   = 1'b1;
        push_byte = ByteZero;
      end
    end else if (is_start) begin
      do_close   = 1'b1;
      zero_run_d = '0;
    end else begin
      do_push    = 1'b1;
      zeros_out  = zero_run_q;
      zero_run_d = '0;
    end
  end

  // pending byte (if any) then the released zeros leave in this burst
  assign beats = BeatW'(pend_valid_q) + BeatW'(zeros_out);

  assign cmd_o.head_byte   = pend_valid_q ? pend_byte_q : ByteZero;
  assign cmd_o.head_first  = pend_valid_q ? pend_first_q : 1'b1;
  assign cmd_o.beats       = beats;
  assign cmd_o.close       = do_close;
  assign cmd_o.unit_number = unit_cnt_q;
  assign push_o = accept && in_unit_q && (do_push || do_close) && (beats != '0);

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    pend_first_d = pend_first_q;
    unit_cnt_d   = unit_cnt_q;
    if (do_close) begin
      pend_valid_d = 1'b0;
      pend_first_d = 1'b0;
      if (beats != '0) unit_cnt_d = unit_cnt_q + 1'b1;
    end else if (do_push) begin
      pend_valid_d = 1'b1;
      pend_byte_d  = push_byte;
      pend_first_d = (beats == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_unit_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_byte_q  <= '0;
      pend_first_q <= 1'b0;
      zero_run_q   <= '0;
      unit_cnt_q   <= '0;
    end else if (accept) begin
      in_unit_q    <= in_unit_d;
      pend_valid_q <= pend_valid_d;
      pend_byte_q  <= pend_byte_d;
      pend_first_q <= pend_first_d;
      zero_run_q   <= zero_run_d;
      unit_cnt_q   <= unit_cnt_d;
    end
  end

endmodule

// File: rtl/annexb_queue.sv
`timescale 1ns / 1ps
// Command queue between front and back ends of the delimiter.
// Small register FIFO of cmd_t entries; uses annexb_pkg.
module annexb_queue
  import annexb_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_data_i,
  input  logic          pop_i,
  output cmd_t          pop_data_o,
  output queue_status_t status_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/annexb_back.sv
`timescale 1ns / 1ps
// Back end: expands queued burst commands into output beats.
// Holds the active command in a register; uses annexb_pkg.
module annexb_back
  import annexb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                queue_empty_i,
  input  cmd_t                queue_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                unit_first_o,
  output logic                unit_last_o,
  output logic [UnitNumW-1:0] unit_number_o,
  output logic                run_last_o
);

  cmd_t             cmd_q;
  logic             busy_q, busy_d;
  logic [BeatW-1:0] idx_q, idx_d;
  logic             last_beat;
  logic             beat_done;

  assign last_beat = (idx_q == cmd_q.beats - 1'b1);
  assign beat_done = busy_q && out_ready_i;
  assign pop_o     = !queue_empty_i && (!busy_q || (beat_done && last_beat));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (beat_done) begin
      if (last_beat) busy_d = 1'b0;
      else idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= queue_data_i;
  end

  assign out_valid_o   = busy_q;
  assign out_byte_o    = (idx_q == '0) ? cmd_q.head_byte : ByteZero;
  assign unit_first_o  = (idx_q == '0) && cmd_q.head_first;
  assign unit_last_o   = cmd_q.close && last_beat;
  assign unit_number_o = cmd_q.unit_number;
  assign run_last_o    = last_beat;

endmodule

// File: rtl/annexb_nal_unit_delimiter.sv
`timescale 1ns / 1ps
// Top level of the Annex B start-code delimiter: front, command queue, back.
// Depends on annexb_pkg, annexb_front, annexb_queue, annexb_back.

// Takes an Annex B byte stream one beat per cycle and returns the payload of
// each NAL unit with start codes removed. Every input beat is accepted as long
// as the command queue (QUEUE_DEPTH entries) has room; a beat that releases
// held bytes queues one command that the back end plays out as 1 to 4 output
// beats, one per cycle while m_axis_tready is high. Sustained rate is one input
// beat per cycle when each beat yields at most one result and the output is
// ready; bursts of released zeros can fill the queue. m_axis_tlast marks the
// last result of an input beat, tuser carries the unit start/end flags.
module annexb_nal_unit_delimiter
  import annexb_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,  // [0] end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [23:8] unit_number
  output logic [1:0]  m_axis_tuser,  // [0] unit_first, [1] unit_last
  output logic        m_axis_tlast   // run_last
);

  cmd_t                push_cmd;
  cmd_t                head_cmd;
  logic                push;
  logic                pop;
  queue_status_t       q_status;
  logic [7:0]          out_byte;
  logic [UnitNumW-1:0] unit_number;
  logic                unit_first;
  logic                unit_last;

  annexb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .data_byte_i     (s_axis_tdata),
    .end_of_stream_i (s_axis_tuser[0]),
    .queue_full_i    (q_status.full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  annexb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .status_o    (q_status)
  );

  annexb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_status.empty),
    .queue_data_i  (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (out_byte),
    .unit_first_o  (unit_first),
    .unit_last_o   (unit_last),
    .unit_number_o (unit_number),
    .run_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {unit_number, out_byte};
  assign m_axis_tuser = {unit_last, unit_first};

`ifndef ASSERT_OFF
  // front never writes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("command pushed into full queue");

  // back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("command popped from empty queue");

  // a unit closes only on the final result of its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("unit end not on last result of a beat");
`endif

endmodule

// File: test/annexb_nal_unit_delimiter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for annexb_nal_unit_delimiter: directed table and
// random unit streams, checked by a predictor.
// Depends on annexb_pkg and the RTL of the block only.
module annexb_nal_unit_delimiter_tb;
  import annexb_pkg::*;

  localparam int StallLimit = 1000;
  localparam int DrainCycles = 40;
  localparam int RandomItems = 170;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                unit_first;
    logic                unit_last;
    logic [UnitNumW-1:0] unit_number;
    logic                run_last;
  } nal_beat_t;

  typedef struct {
    logic [7:0] data_b;
    logic       eos;
    bit         typed;
    nal_beat_t  want;
  } stim_row_t;

  typedef enum int {RxOpen, RxRandom, RxComb, RxSlow} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  annexb_nal_unit_delimiter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicted delimiter state
  logic                unit_open = 1'b0;
  logic                pend_valid = 1'b0;
  logic [7:0]          pend_byte = 8'h00;
  logic                pend_first = 1'b0;
  int                  held_zeros = 0;
  logic [UnitNumW-1:0] units_done = '0;

  nal_beat_t payload_due[$];
  nal_beat_t step_beats[$];
  stim_row_t directed_rows[$];

  int  mismatches = 0;
  int  burst_left = 0;
  int  live_items = 0;
  bit  checking = 1'b0;

  task automatic emit_beat(input logic [7:0] b, input logic is_first, input logic is_last);
    nal_beat_t r;
    r.out_byte    = b;
    r.unit_first  = is_first;
    r.unit_last   = is_last;
    r.unit_number = units_done;
    r.run_last    = 1'b0;
    step_beats.insert(step_beats.size(), r);
  endtask

  // One byte stays pending so the unit's last byte can be flagged on close.
  task automatic queue_payload(input logic [7:0] b);
    if (pend_valid) emit_beat(pend_byte, pend_first, 1'b0);
    pend_first = !pend_valid;
    pend_byte  = b;
    pend_valid = 1'b1;
  endtask

  task automatic end_unit();
    if (pend_valid) begin
      emit_beat(pend_byte, pend_first, 1'b1);
      units_done = units_done + 16'd1;
    end
    pend_valid = 1'b0;
    pend_first = 1'b0;
  endtask

  task automatic predict_payload(input logic [7:0] b, input logic eos);
    int i;
    step_beats.delete();
    if (eos) begin
      if (unit_open) begin
        for (i = 0; i < held_zeros; i++) queue_payload(ByteZero);
        end_unit();
      end
      unit_open  = 1'b0;
      held_zeros = 0;
    end else if (!unit_open) begin
      if (b == ByteZero) begin
        if (held_zeros < MaxHeldZeros) held_zeros++;
      end else begin
        if (b == ByteOne && held_zeros >= 2) unit_open = 1'b1;
        held_zeros = 0;
      end
    end else if (b == ByteZero) begin
      // full hold: the oldest zero falls out as payload
      if (held_zeros < MaxHeldZeros) held_zeros++;
      else queue_payload(ByteZero);
    end else if (b == ByteOne && held_zeros >= 2) begin
      held_zeros = 0;
      end_unit();
    end else begin
      for (i = 0; i < held_zeros; i++) queue_payload(ByteZero);
      held_zeros = 0;
      queue_payload(b);
    end
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].run_last = 1'b1;
  endtask

  // Drives one beat and returns at the edge that accepts it.
  task automatic send_beat(input logic [7:0] b, input logic eos, input bit typed = 1'b0,
                           input nal_beat_t want = '0);
    logic ok;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eos;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk_i);
      ok = s_axis_tready;
      if (ok) begin
        predict_payload(b, eos);
        if (typed) payload_due.insert(payload_due.size(), want);
        else foreach (step_beats[i]) payload_due.insert(payload_due.size(), step_beats[i]);
      end
      @(posedge clk_i);
    end
  endtask

  task automatic send_counted(input logic [7:0] b, input logic eos);
    live_items++;
    send_beat(b, eos);
  endtask

  task automatic add_row(input logic [7:0] b, input logic eos, input bit typed = 1'b0,
                         input nal_beat_t want = '0);
    stim_row_t r;
    r.data_b = b;
    r.eos    = eos;
    r.typed  = typed;
    r.want   = want;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Biased toward zeros and ones so start codes form inside payloads too.
  function automatic logic [7:0] random_payload_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return ByteZero;
    if (r == 3) return ByteOne;
    if (r == 4) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Output stall pattern, independent of the sender
  rx_mode_e rx_mode = RxOpen;
  int       rx_left = 0;
  int       rx_tick = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RxOpen:   m_axis_tready <= 1'b1;
      RxRandom: m_axis_tready <= ($urandom_range(0, 9) < 7);
      RxComb:   m_axis_tready <= (rx_tick % 5 != 0) && (rx_tick % 7 != 3);
      default:  m_axis_tready <= (rx_tick % 16) < 4;
    endcase
  end

  // Handshakes are sampled mid-cycle and acted on at the following edge.
  logic      out_fire = 1'b0;
  logic      any_fire = 1'b0;
  nal_beat_t seen_beat = '0;
  int        stuck_cycles = 0;

  always @(negedge clk_i) begin
    out_fire  = m_axis_tvalid && m_axis_tready;
    any_fire  = out_fire || (s_axis_tvalid && s_axis_tready);
    seen_beat = {m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[23:8],
                 m_axis_tlast};
  end

  task automatic report_beat(input string what, input nal_beat_t want, input nal_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at %0t: expected byte %02h first %0d last %0d unit %0d tlast %0d,",
               what, $realtime, want.out_byte, want.unit_first, want.unit_last,
               want.unit_number, want.run_last);
      $display("  got byte %02h first %0d last %0d unit %0d tlast %0d",
               got.out_byte, got.unit_first, got.unit_last, got.unit_number,
               got.run_last);
    end
  endtask

  always @(posedge clk_i) begin
    nal_beat_t want;
    if (checking) begin
      if (any_fire) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
      if (out_fire) begin
        if (payload_due.size() == 0) begin
          report_beat("unexpected beat", '0, seen_beat);
        end else begin
          want = payload_due.pop_front();
          if (seen_beat.out_byte !== want.out_byte || seen_beat.unit_first !== want.unit_first ||
              seen_beat.unit_last !== want.unit_last ||
              seen_beat.unit_number !== want.unit_number ||
              seen_beat.run_last !== want.run_last)
            report_beat("mismatch", want, seen_beat);
        end
      end
    end
  end

  initial begin
    int sel;
    // searching: stray bytes, then a start code opens the first unit
    add_row(8'hFF, 1'b0);
    add_row(ByteOne, 1'b0);
    repeat (2) add_row(ByteZero, 1'b0);
    add_row(ByteOne, 1'b0);
    add_row(8'hAB, 1'b0);
    repeat (3) add_row(ByteZero, 1'b0);
    // fourth zero pushes out the pending byte
    add_row(ByteZero, 1'b0, 1'b1, {8'hAB, 1'b1, 1'b0, 16'd0, 1'b1});
    // releases the pending zero and three held zeros: four results
    add_row(8'h7F, 1'b0);
    repeat (2) add_row(ByteZero, 1'b0);
    add_row(ByteOne, 1'b0, 1'b1, {8'h7F, 1'b0, 1'b1, 16'd0, 1'b1});
    // empty unit
    repeat (2) add_row(ByteZero, 1'b0);
    add_row(ByteOne, 1'b0);
    add_row(ByteZero, 1'b0);
    add_row(8'hFF, 1'b0);
    repeat (2) add_row(ByteZero, 1'b0);
    add_row(8'h00, 1'b1);
    // end of stream while searching drops the zero
    add_row(ByteZero, 1'b0);
    add_row(8'hFF, 1'b1);
    repeat (3) add_row(ByteZero, 1'b0);
    add_row(ByteOne, 1'b0);
    add_row(ByteOne, 1'b0);
    add_row(8'h5A, 1'b1, 1'b1, {8'h01, 1'b1, 1'b1, 16'd2, 1'b1});

    repeat (9) @(posedge clk_i);
    rst_ni   <= 1'b1;
    checking <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].data_b, directed_rows[i].eos, directed_rows[i].typed,
                directed_rows[i].want);

    while (live_items < RandomItems) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        send_counted(8'($urandom_range(0, 255)), 1'b1);
      end else if (sel == 1) begin
        repeat ($urandom_range(1, 4)) send_counted(random_payload_byte(), 1'b0);
      end else if (sel == 2) begin
        // broken start codes
        if ($urandom_range(0, 1)) begin
          send_counted(ByteZero, 1'b0);
          send_counted(ByteOne, 1'b0);
        end else begin
          repeat (2) send_counted(ByteZero, 1'b0);
          send_counted(8'($urandom_range(2, 255)), 1'b0);
        end
      end else begin
        repeat ($urandom_range(2, 4)) send_counted(ByteZero, 1'b0);
        send_counted(ByteOne, 1'b0);
        repeat ($urandom_range(0, 10)) send_counted(random_payload_byte(), 1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (payload_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && payload_due.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
